// File: hdl/rtlpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table package
// Types, command and status codes shared by the route table modules.
// ----------------------------------------------------------------------------
package rtlpm_pkg;

   typedef enum logic [2:0] {
      CMD_LOOKUP    = 3'd0,
      CMD_ADD       = 3'd1,
      CMD_DELETE    = 3'd2,
      CMD_CLEAR     = 3'd3,
      CMD_CLEAR_ALL = 3'd4
   } cmd_type;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EXISTS   = 3'd1;
   localparam logic [2:0] ST_NOSPACE  = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_INVALID  = 3'd4;

   localparam int ENTRY_W = 146;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [2:0]  tbl_sel;
      logic [31:0] dst_ip;
      logic [5:0]  prefix_len;
      logic [3:0]  route_class;
      logic [31:0] gateway;
      logic [7:0]  port_id;
      logic [31:0] source;
      logic [15:0] mtu;
      logic [15:0] port_mtu;
      logic signed [15:0] metric;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        hit;
      logic [3:0]  found_class;
      logic [31:0] found_dest;
      logic [5:0]  found_len;
      logic [31:0] found_gateway;
      logic [7:0]  found_port;
      logic [31:0] found_source;
      logic [15:0] found_mtu;
      logic signed [15:0] found_metric;
   } rsp_type;

   // one stored route
   typedef struct packed {
      logic [31:0] dest;
      logic [5:0]  len;
      logic [31:0] gateway;
      logic [31:0] source;
      logic [3:0]  cls;
      logic [7:0]  port;
      logic [15:0] mtu;
      logic [15:0] metric;
   } entry_type;

   // datapath commands
   typedef struct packed {
      logic load;        // capture request
      logic rd;          // issue read at rd_idx
      logic wr;          // write wr_data at wr_idx
      logic sel_net;     // list being worked on
      logic wr_new;      // write data comes from request, else last read
   } dp_cmd_type;

   typedef struct packed {
      logic exact;       // local exact match on dest
      logic exact_port;  // local match on dest and port
      logic net_hit;     // lookup prefix covers
      logic net_dup;     // add duplicate
      logic net_shorter; // stored length below request length
      logic net_del;     // delete match
   } dp_sts_type;

   function automatic logic [31:0] len_mask(input logic [5:0] len);
      logic [31:0] m;
      if (len == 6'd0) m = 32'd0;
      else if (len >= 6'd32) m = 32'hFFFF_FFFF;
      else m = ~(32'hFFFF_FFFF >> len[4:0]);
      return m;
   endfunction

endpackage

// File: hdl/rtlpm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface rtlpm_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/rtlpm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, one registered read port.
// ----------------------------------------------------------------------------
module rtlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: hdl/rtlpm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table datapath
// Request register, list memories and entry compare logic.
// ----------------------------------------------------------------------------
module rtlpm_datapath #(
   parameter int TABLES        = 8,
   parameter int NET_ENTRIES   = 64,
   parameter int LOCAL_ENTRIES = 64,
   parameter int AW            = 10
) (
   input  logic                   clock,
   input  rtlpm_pkg::req_type     req_in,
   input  rtlpm_pkg::dp_cmd_type  cmd,
   input  logic [AW-1:0]          rd_idx,
   input  logic [AW-1:0]          wr_idx,
   output rtlpm_pkg::req_type     req_q,
   output rtlpm_pkg::entry_type   rd_entry,
   output rtlpm_pkg::dp_sts_type  sts
);
   import rtlpm_pkg::*;

   localparam int TW  = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int NW  = $clog2(NET_ENTRIES);
   localparam int LW  = $clog2(LOCAL_ENTRIES);
   localparam int NAW = TW + NW;
   localparam int LAW = TW + LW;

   req_type   req_ff;
   entry_type new_e, wr_e, net_rd, loc_rd;
   logic      sel_ff;
   logic [TW-1:0] tab;
   logic [31:0] m_e, m_r;

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_in;
      if (cmd.rd) sel_ff <= cmd.sel_net;
   end

   assign tab = (TABLES > 1) ? TW'(req_ff.tbl_sel) : '0;

   always_comb begin
      new_e.dest    = req_ff.dst_ip;
      new_e.len     = req_ff.prefix_len;
      new_e.gateway = req_ff.gateway;
      new_e.source  = req_ff.source;
      new_e.cls     = req_ff.route_class;
      new_e.port    = req_ff.port_id;
      new_e.mtu     = (req_ff.mtu != 16'd0) ? req_ff.mtu : req_ff.port_mtu;
      new_e.metric  = req_ff.metric;
   end

   assign rd_entry = sel_ff ? net_rd : loc_rd;
   assign wr_e     = cmd.wr_new ? new_e : rd_entry;

   // one power-of-two segment per table
   rtlpm_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << NAW)) u_net (
      .clock  (clock),
      .wr_en  (cmd.wr && cmd.sel_net),
      .wr_addr({tab, wr_idx[NW-1:0]}),
      .wr_data(wr_e),
      .rd_addr({tab, rd_idx[NW-1:0]}),
      .rd_data(net_rd)
   );

   rtlpm_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << LAW)) u_loc (
      .clock  (clock),
      .wr_en  (cmd.wr && !cmd.sel_net),
      .wr_addr({tab, wr_idx[LW-1:0]}),
      .wr_data(wr_e),
      .rd_addr({tab, rd_idx[LW-1:0]}),
      .rd_data(loc_rd)
   );

   always_comb begin
      m_e = len_mask(rd_entry.len);
      m_r = len_mask(req_ff.prefix_len);
      sts.exact       = rd_entry.dest == req_ff.dst_ip;
      sts.exact_port  = sts.exact && rd_entry.port == req_ff.port_id;
      sts.net_hit     = (req_ff.dst_ip & m_e) == (rd_entry.dest & m_e);
      sts.net_dup     = rd_entry.port == req_ff.port_id
                        && rd_entry.len == req_ff.prefix_len
                        && (req_ff.dst_ip & m_r) == (rd_entry.dest & m_r);
      sts.net_shorter = rd_entry.len < req_ff.prefix_len;
      sts.net_del     = rd_entry.port == req_ff.port_id
                        && (req_ff.dst_ip & m_r) == (rd_entry.dest & m_e);
   end

   assign req_q = req_ff;
endmodule

// File: hdl/rtlpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table controller
// Sequences scans, slot shifts and fill counts; forms the response.
// ----------------------------------------------------------------------------
module rtlpm_ctrl #(
   parameter int TABLES        = 8,
   parameter int NET_ENTRIES   = 64,
   parameter int LOCAL_ENTRIES = 64,
   parameter int AW            = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rtlpm_pkg::rsp_type     rsp_data,
   input  rtlpm_pkg::req_type     req_q,
   input  rtlpm_pkg::entry_type   rd_entry,
   input  rtlpm_pkg::dp_sts_type  sts,
   output rtlpm_pkg::dp_cmd_type  cmd,
   output logic [AW-1:0]          rd_idx,
   output logic [AW-1:0]          wr_idx
);
   import rtlpm_pkg::*;

   localparam int TW = (TABLES > 1) ? $clog2(TABLES) : 1;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_DEC   = 8'b0000_0010,
      S_RD    = 8'b0000_0100,
      S_CHK   = 8'b0000_1000,
      S_SHRD  = 8'b0001_0000,
      S_SHWR  = 8'b0010_0000,
      S_PUT   = 8'b0100_0000,
      S_RSP   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [AW:0] fill_l_ff [TABLES];
   logic [AW:0] fill_n_ff [TABLES];
   logic [AW:0] idx_ff, idx_in, pos_ff, pos_in;
   logic        net_ff, net_in, del_ff, del_in;
   rsp_type     rsp_ff, rsp_in;
   logic [TW-1:0] tab;
   logic [AW:0] fill, cap;
   logic        loc, net, bad_tab;
   logic        inc_fill, dec_fill, clr_one, clr_all;

   assign tab     = (TABLES > 1) ? TW'(req_q.tbl_sel) : '0;
   assign bad_tab = 32'(req_q.tbl_sel) >= TABLES;
   assign loc     = req_q.route_class[1:0] != 2'b00;
   assign net     = req_q.route_class[3:2] != 2'b00;
   assign fill    = net_ff ? fill_n_ff[tab] : fill_l_ff[tab];
   assign cap     = net_ff ? (AW+1)'(NET_ENTRIES) : (AW+1)'(LOCAL_ENTRIES);
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RSP;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      net_in = net_ff;
      del_in = del_ff;
      rsp_in = rsp_ff;
      cmd = '0;
      cmd.sel_net = net_ff;
      rd_idx = idx_ff[AW-1:0];
      wr_idx = idx_ff[AW-1:0];
      inc_fill = 1'b0;
      dec_fill = 1'b0;
      clr_one = 1'b0;
      clr_all = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = 1'b1;
            if (req_valid) state_in = S_DEC;
         end
         S_DEC: begin
            rsp_in = '0;
            idx_in = '0;
            del_in = 1'b0;
            state_in = S_RSP;
            net_in = !loc;
            if (req_q.cmd == CMD_CLEAR_ALL) begin
               clr_all = 1'b1;
               rsp_in.status = ST_OK;
            end else if (req_q.cmd > CMD_CLEAR_ALL) begin
               rsp_in.status = ST_INVALID;
            end else if (bad_tab) begin
               rsp_in.status = ST_NOTFOUND;
            end else if (req_q.cmd == CMD_CLEAR) begin
               clr_one = 1'b1;
               rsp_in.status = ST_OK;
            end else if (!loc && !net) begin
               rsp_in.status = ST_INVALID;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            // end of list reached
            if (idx_ff >= fill) begin
               state_in = S_RSP;
               if (req_q.cmd == CMD_LOOKUP && !net_ff && net) begin
                  net_in = 1'b1;
                  idx_in = '0;
                  state_in = S_RD;
               end else if (req_q.cmd == CMD_ADD) begin
                  if (fill >= cap) rsp_in.status = ST_NOSPACE;
                  else begin
                     pos_in = net_ff ? fill : '0;
                     idx_in = fill;
                     state_in = (idx_in == pos_in) ? S_PUT : S_SHRD;
                     if (fill == '0 || (net_ff && 1'b1)) state_in = S_PUT;
                     if (!net_ff && fill != '0) state_in = S_SHRD;
                  end
               end else rsp_in.status = ST_NOTFOUND;
            end else begin
               cmd.rd = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            state_in = S_RD;
            idx_in = idx_ff + 1'b1;
            unique case (req_q.cmd)
               CMD_LOOKUP: begin
                  if (net_ff ? sts.net_hit : sts.exact) begin
                     rsp_in.status = ST_OK;
                     rsp_in.hit = 1'b1;
                     rsp_in.found_class = rd_entry.cls;
                     rsp_in.found_dest = rd_entry.dest;
                     rsp_in.found_len = rd_entry.len;
                     rsp_in.found_gateway = rd_entry.gateway;
                     rsp_in.found_port = rd_entry.port;
                     rsp_in.found_source = rd_entry.source;
                     rsp_in.found_mtu = rd_entry.mtu;
                     rsp_in.found_metric = rd_entry.metric;
                     state_in = S_RSP;
                  end
               end
               CMD_ADD: begin
                  if (net_ff ? sts.net_dup : sts.exact_port) begin
                     rsp_in.status = ST_EXISTS;
                     state_in = S_RSP;
                  end else if (net_ff && sts.net_shorter) begin
                     if (fill >= cap) begin
                        rsp_in.status = ST_NOSPACE;
                        state_in = S_RSP;
                     end else begin
                        pos_in = idx_ff;
                        idx_in = fill;
                        state_in = S_SHRD;
                     end
                  end
               end
               default: begin
                  if (net_ff ? sts.net_del : sts.exact_port) begin
                     // close the slot: move later entries down one
                     del_in = 1'b1;
                     rsp_in.status = ST_OK;
                     idx_in = idx_ff + 1'b1;
                     state_in = S_SHRD;
                  end
               end
            endcase
         end
         S_SHRD: begin
            if (del_ff) begin
               if (idx_ff >= fill) begin
                  dec_fill = 1'b1;
                  state_in = S_RSP;
               end else begin
                  cmd.rd = 1'b1;
                  state_in = S_SHWR;
               end
            end else begin
               if (idx_ff == pos_ff) state_in = S_PUT;
               else begin
                  rd_idx = AW'(idx_ff - 1'b1);
                  cmd.rd = 1'b1;
                  state_in = S_SHWR;
               end
            end
         end
         S_SHWR: begin
            cmd.wr = 1'b1;
            if (del_ff) begin
               wr_idx = AW'(idx_ff - 1'b1);
               idx_in = idx_ff + 1'b1;
            end else idx_in = idx_ff - 1'b1;
            state_in = S_SHRD;
         end
         S_PUT: begin
            cmd.wr = 1'b1;
            cmd.wr_new = 1'b1;
            wr_idx = pos_ff[AW-1:0];
            inc_fill = 1'b1;
            rsp_in.status = ST_OK;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int t = 0; t < TABLES; t++) begin
            fill_l_ff[t] <= '0;
            fill_n_ff[t] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (clr_all) begin
            for (int t = 0; t < TABLES; t++) begin
               fill_l_ff[t] <= '0;
               fill_n_ff[t] <= '0;
            end
         end else if (clr_one) begin
            fill_l_ff[tab] <= '0;
            fill_n_ff[tab] <= '0;
         end else if (inc_fill || dec_fill) begin
            if (net_ff) fill_n_ff[tab] <= inc_fill ? fill + 1'b1 : fill - 1'b1;
            else        fill_l_ff[tab] <= inc_fill ? fill + 1'b1 : fill - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      net_ff <= net_in;
      del_ff <= del_in;
      rsp_ff <= rsp_in;
   end
endmodule

// File: hdl/ipv4_route_table_lpm.sv
`timescale 1ns / 1ps
// Clears and rejected commands respond straight from decode; a lookup reads
// each entry of the local list and then of the net list, as the class selects;
// a delete scans and then moves later entries down, and an add scans and then
// moves entries up to open its slot.
// One command at a time, the next taken the cycle after the response transfer.
// Synchronous reset clears the fill counts; list memories are not cleared.
// ----------------------------------------------------------------------------
// IPv4 route table with longest prefix match
// Per-table local exact list and length-ordered net list with lookup,
// add, delete and clear commands.
// ----------------------------------------------------------------------------
module ipv4_route_table_lpm #(
   parameter int TABLES        = 8,
   parameter int NET_ENTRIES   = 64,
   parameter int LOCAL_ENTRIES = 64
) (
   input  logic clock,
   input  logic reset,
   rtlpm_if.sink   req,
   rtlpm_if.source rsp
);
   import rtlpm_pkg::*;

   localparam int AW = (NET_ENTRIES > LOCAL_ENTRIES) ?
                       $clog2(NET_ENTRIES) : $clog2(LOCAL_ENTRIES);

   req_type    req_q;
   entry_type  rd_entry;
   dp_sts_type sts;
   dp_cmd_type cmd;
   logic [AW-1:0] rd_idx, wr_idx;

   rtlpm_datapath #(.TABLES(TABLES), .NET_ENTRIES(NET_ENTRIES),
                    .LOCAL_ENTRIES(LOCAL_ENTRIES), .AW(AW)) u_dp (
      .clock(clock), .req_in(req.data), .cmd(cmd), .rd_idx(rd_idx),
      .wr_idx(wr_idx), .req_q(req_q), .rd_entry(rd_entry), .sts(sts)
   );

   rtlpm_ctrl #(.TABLES(TABLES), .NET_ENTRIES(NET_ENTRIES),
                .LOCAL_ENTRIES(LOCAL_ENTRIES), .AW(AW)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
      .req_q(req_q), .rd_entry(rd_entry), .sts(sts), .cmd(cmd),
      .rd_idx(rd_idx), .wr_idx(wr_idx)
   );
endmodule
